### rtl/srdb_pkg.sv
// Shared constants for the stereo RMS dB level meter.
package srdb_pkg;
    localparam int MAX_FRAMES = 65536;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W = 30 + CNT_W;
    localparam int TOP_W = $clog2(SUM_W);
    localparam int LOG_W = TOP_W + 16;
    localparam logic [19:0] DB_SLOPE_Q24 = 20'd841741;
    localparam logic [15:0] GAIN_RESET = 16'd4096;
    localparam logic [15:0] LEVEL_MAX = 16'd32768;
endpackage

### rtl/stereo_rms_db_level_meter.sv
// Top level of the stereo RMS dB level meter.
// Sequence: a last frame runs four log2 passes, two per side (sum, then count), and
//   each side then steps through S_MUL, S_NORM, S_GAIN and S_OUT before the result
//   beat rises.
// Throughput: one frame per cycle between last marks; in_stall stays high from a
//   last frame until its result beat is taken. Reset: sums and count clear, gain 4096.
module stereo_rms_db_level_meter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic        last_frame,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] left_level,
    output logic [15:0] right_level
);
    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_LOG   = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_GAIN  = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;

    logic [3:0]  st_reg;
    logic [15:0] gain_reg;
    logic [srdb_pkg::SUM_W-1:0] lsum_reg;
    logic [srdb_pkg::SUM_W-1:0] rsum_reg;
    logic [srdb_pkg::CNT_W-1:0] cnt_reg;
    logic [1:0]  op_reg;      // which log: 0 lsum,1 cnt,2 rsum,3 cnt
    logic [srdb_pkg::LOG_W-1:0] lg_reg;
    logic signed [srdb_pkg::LOG_W+1:0] d_reg;
    logic        neg_reg;
    logic [41:0] prod_reg;
    logic signed [18:0] norm_reg;
    logic [36:0] lvl_reg;
    logic        zero_reg;
    logic [15:0] l_reg;
    logic [15:0] r_reg;
    logic        side_reg;

    logic        acc_fire;
    logic        log_start;
    logic        log_done;
    logic [srdb_pkg::LOG_W-1:0] log_res;
    logic [srdb_pkg::SUM_W-1:0] log_x;
    logic [15:0] la;
    logic [15:0] ra;
    logic signed [srdb_pkg::LOG_W+1:0] d_full;
    logic [srdb_pkg::LOG_W+1:0] mag;
    logic [15:0] lvl_sat;

    assign in_stall  = (st_reg != S_ACC) || out_valid;
    assign acc_fire  = in_valid && !in_stall;
    assign la        = left_sample[15] ? 16'(-left_sample) : 16'(left_sample);
    assign ra        = right_sample[15] ? 16'(-right_sample) : 16'(right_sample);
    assign log_start = (st_reg == S_LOG);
    assign log_x     = (op_reg == 2'd0) ? lsum_reg :
                       (op_reg == 2'd2) ? rsum_reg :
                       srdb_pkg::SUM_W'(cnt_reg);
    assign left_level  = l_reg;
    assign right_level = r_reg;

    srdb_log2 u_log
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    // D = log2(sum) - log2(count) - 30 in Q.16
    assign d_full = $signed({2'b00, lg_reg}) - $signed({2'b00, log_res})
                    - $signed((srdb_pkg::LOG_W+2)'(30 << 16));
    assign mag = d_reg[srdb_pkg::LOG_W+1] ? (srdb_pkg::LOG_W+2)'(-d_reg)
                                         : (srdb_pkg::LOG_W+2)'(d_reg);
    assign lvl_sat = (lvl_reg > 37'(srdb_pkg::LEVEL_MAX)) ? srdb_pkg::LEVEL_MAX
                                                          : lvl_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_ACC;
            gain_reg  <= srdb_pkg::GAIN_RESET;
            lsum_reg  <= '0;
            rsum_reg  <= '0;
            cnt_reg   <= '0;
            op_reg    <= 2'd0;
            out_valid <= 1'b0;
            side_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                gain_reg <= cfg_wdata;
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            case (st_reg)
                S_ACC:
                begin
                    if (acc_fire)
                    begin
                        // drop frames past the block bound, still honor last
                        if (cnt_reg < srdb_pkg::CNT_W'(srdb_pkg::MAX_FRAMES))
                        begin
                            lsum_reg <= lsum_reg
                                        + srdb_pkg::SUM_W'({16'd0, la} * {16'd0, la});
                            rsum_reg <= rsum_reg
                                        + srdb_pkg::SUM_W'({16'd0, ra} * {16'd0, ra});
                            cnt_reg  <= cnt_reg + 1'b1;
                        end
                        if (last_frame)
                        begin
                            op_reg   <= 2'd0;
                            side_reg <= 1'b0;
                            st_reg   <= S_LOG;
                        end
                    end
                end
                S_LOG:  st_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (log_done)
                    begin
                        if (!op_reg[0])
                        begin
                            lg_reg   <= log_res;
                            zero_reg <= (log_x == '0);
                            op_reg   <= op_reg + 1'b1;
                            st_reg   <= S_LOG;
                        end
                        else
                        begin
                            d_reg  <= d_full;
                            st_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    neg_reg  <= d_reg[srdb_pkg::LOG_W+1];
                    prod_reg <= 42'(mag) * 42'(srdb_pkg::DB_SLOPE_Q24);
                    st_reg   <= S_NORM;
                end
                S_NORM:
                begin
                    norm_reg <= neg_reg
                        ? 19'sd65536 - $signed({1'b0, 18'((prod_reg + 42'd8388608) >> 24)})
                        : 19'sd65536 + $signed({1'b0, 18'((prod_reg + 42'd8388608) >> 24)});
                    st_reg   <= S_GAIN;
                end
                S_GAIN:
                begin
                    if (zero_reg || norm_reg <= 0)
                        lvl_reg <= '0;
                    else
                        lvl_reg <= (37'(gain_reg) * 37'(norm_reg[17:0]) + 37'd4096) >> 13;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!side_reg)
                    begin
                        l_reg    <= lvl_sat;
                        side_reg <= 1'b1;
                        op_reg   <= 2'd2;
                        st_reg   <= S_LOG;
                    end
                    else if (!out_valid)
                    begin
                        r_reg     <= lvl_sat;
                        out_valid <= 1'b1;
                        lsum_reg  <= '0;
                        rsum_reg  <= '0;
                        cnt_reg   <= '0;
                        st_reg    <= S_ACC;
                    end
                end
                default: st_reg <= S_ACC;
            endcase
        end
    end
endmodule

### rtl/srdb_log2.sv
// Iterative log2 in Q.16 with a single squaring multiplier.
module srdb_log2
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [srdb_pkg::SUM_W-1:0]    x,
    output logic                          done,
    output logic [srdb_pkg::LOG_W-1:0]    result
);
    logic [1:0]  st_reg;
    logic [1:0]  st_next;
    logic [31:0] m_reg;
    logic [31:0] m_next;
    logic [15:0] frac_reg;
    logic [15:0] frac_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [srdb_pkg::TOP_W-1:0] top_reg;
    logic [srdb_pkg::TOP_W-1:0] top_next;
    logic [srdb_pkg::SUM_W-1:0] x_reg;
    logic [srdb_pkg::SUM_W-1:0] x_next;
    logic [63:0] sq;
    logic [33:0] msq;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NORM = 2'd1;
    localparam logic [1:0] S_SQ   = 2'd2;

    assign sq     = {32'd0, m_reg} * {32'd0, m_reg};
    assign msq    = sq[63:30];
    assign result = {top_reg, frac_reg};
    assign done   = (st_reg == S_SQ) && (cnt_reg == 5'd16);

    always_comb
    begin
        st_next   = st_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        top_next  = top_reg;
        x_next    = x_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    x_next   = x;
                    top_next = srdb_pkg::TOP_W'(srdb_pkg::SUM_W - 1);
                    st_next  = S_NORM;
                end
            end
            S_NORM:
            begin
                // find top set bit one position a cycle
                if (x_reg[srdb_pkg::SUM_W-1] || top_reg == '0)
                begin
                    m_next   = {1'b0, x_reg[srdb_pkg::SUM_W-1 -: 31]};
                    cnt_next = 5'd0;
                    frac_next = 16'd0;
                    st_next  = S_SQ;
                end
                else
                begin
                    x_next   = x_reg << 1;
                    top_next = top_reg - 1'b1;
                end
            end
            S_SQ:
            begin
                if (cnt_reg == 5'd16)
                    st_next = S_IDLE;
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (msq[31])
                    begin
                        m_next    = msq[32:1];
                        frac_next = {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        m_next    = msq[31:0];
                        frac_next = {frac_reg[14:0], 1'b0};
                    end
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= 5'd0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        top_reg  <= top_next;
        x_reg    <= x_next;
    end
endmodule
